// File: sv/efd_pkg.sv
// Shared types and constants for the escaped frame decoder.
// No dependencies; imported by every module of the block.
package efd_pkg;

  localparam logic [7:0] HEAD_TAIL_BYTE = 8'hFF;
  localparam logic [7:0] ESC_BYTE       = 8'hFE;
  localparam logic [7:0] ESC_FF_CODE    = 8'hFD;
  localparam logic [7:0] ESC_FE_CODE    = 8'hFC;

  localparam logic [7:0] HEARTBEAT_LEN = 8'd15;
  localparam logic [7:0] PROFILE_LEN   = 8'd9;
  localparam logic [7:0] PORT_POS      = 8'd2;
  localparam logic [7:0] ESC_START     = 8'd4;
  localparam logic [7:0] COUNT_MAX     = 8'd255;

  localparam int PAYLOAD_BASE  = 5;
  localparam int PAYLOAD_DEPTH = 10;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEARTBEAT_IDX = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROFILE_IDX   = 2'd1;

  localparam logic [7:0] HEARTBEAT_CODE_RST = 8'd1;
  localparam logic [7:0] PROFILE_CODE_RST   = 8'd2;

  typedef enum logic [2:0] {
    RPT_HEARTBEAT     = 3'd0,
    RPT_PROFILE       = 3'd1,
    RPT_BAD_HEARTBEAT = 3'd2,
    RPT_BAD_PROFILE   = 3'd3,
    RPT_UNKNOWN_PORT  = 3'd4
  } report_kind_e;

  // One finished frame as handed from the front end to the back end.
  typedef struct packed {
    logic [7:0]                         count;
    logic [7:0]                         port;
    logic [PAYLOAD_DEPTH-1:0][7:0]      payload;
  } frame_rec_t;

endpackage

// File: sv/efd_front.sv
// Front end: strips head bytes, undoes byte stuffing and collects the body.
// Depends on efd_pkg; emits one frame record per tail of a long enough body.
module efd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          rx_byte_i,
  output logic                rec_valid_o,
  output efd_pkg::frame_rec_t rec_o
);
  import efd_pkg::*;

  logic                          in_body_q, in_body_d;
  logic                          esc_q, esc_d;
  logic [7:0]                    count_q, count_d;
  logic [7:0]                    port_q, port_d;
  logic [PAYLOAD_DEPTH-1:0][7:0] payload_q, payload_d;

  logic       p0, p1;
  logic [7:0] v0, v1;
  logic [7:0] c1, c2;
  logic       emit;

  assign c1 = (count_q == COUNT_MAX) ? COUNT_MAX : count_q + 8'd1;
  assign c2 = (c1 == COUNT_MAX) ? COUNT_MAX : c1 + 8'd1;

  // Up to two decoded bytes land in one cycle: a released escape byte
  // followed by the plain byte that broke the escape.
  always_comb begin
    p0        = 1'b0;
    p1        = 1'b0;
    v0        = rx_byte_i;
    v1        = rx_byte_i;
    esc_d     = esc_q;
    in_body_d = in_body_q;
    emit      = 1'b0;
    if (!in_body_q) begin
      in_body_d = 1'b1;
      esc_d     = 1'b0;
    end else if (rx_byte_i != HEAD_TAIL_BYTE) begin
      if (esc_q) begin
        esc_d = 1'b0;
        p0    = 1'b1;
        if (rx_byte_i == ESC_FF_CODE) begin
          v0 = HEAD_TAIL_BYTE;
        end else if (rx_byte_i == ESC_FE_CODE) begin
          v0 = ESC_BYTE;
        end else begin
          v0 = ESC_BYTE;
          if (rx_byte_i == ESC_BYTE && c1 >= ESC_START) begin
            esc_d = 1'b1;
          end else begin
            p1 = 1'b1;
          end
        end
      end else if (rx_byte_i == ESC_BYTE && count_q >= ESC_START) begin
        esc_d = 1'b1;
      end else begin
        p0 = 1'b1;
      end
    end else begin
      // Tail: a pending escape is kept as a literal FE.
      if (esc_q) begin
        p0 = 1'b1;
        v0 = ESC_BYTE;
      end
      esc_d     = 1'b0;
      in_body_d = 1'b0;
      emit      = 1'b1;
    end
  end

  always_comb begin
    if (!in_body_q) begin
      count_d = '0;
    end else if (p1) begin
      count_d = c2;
    end else if (p0) begin
      count_d = c1;
    end else begin
      count_d = count_q;
    end

    port_d = port_q;
    if (p0 && count_q == PORT_POS) begin
      port_d = v0;
    end
    if (p1 && c1 == PORT_POS) begin
      port_d = v1;
    end

    payload_d = payload_q;
    for (int i = 0; i < PAYLOAD_DEPTH; i++) begin
      if (p0 && count_q == 8'(PAYLOAD_BASE + i)) begin
        payload_d[i] = v0;
      end
      if (p1 && c1 == 8'(PAYLOAD_BASE + i)) begin
        payload_d[i] = v1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_body_q <= 1'b0;
      esc_q     <= 1'b0;
      count_q   <= '0;
      port_q    <= '0;
    end else if (accept_i) begin
      in_body_q <= in_body_d;
      esc_q     <= esc_d;
      count_q   <= count_d;
      port_q    <= port_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      payload_q <= payload_d;
    end
  end

  // Bodies with no port byte are dropped without a record.
  assign rec_valid_o   = accept_i && emit && (count_d > PORT_POS);
  assign rec_o.count   = count_d;
  assign rec_o.port    = port_d;
  assign rec_o.payload = payload_d;

endmodule

// File: sv/efd_frame_fifo.sv
// Short queue of finished frame records between the front and back ends.
// Depends on efd_pkg for the record type and the queue depth.
module efd_frame_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  efd_pkg::frame_rec_t wr_data_i,
  input  logic                rd_en_i,
  output efd_pkg::frame_rec_t rd_data_o,
  output logic                full_o,
  output logic                empty_o
);
  import efd_pkg::*;

  frame_rec_t            mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0] cnt_q;
  logic                  do_wr, do_rd;

  assign full_o  = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_en_i && !full_o;
  assign do_rd   = rd_en_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  assign rd_data_o = mem_q[rd_ptr_q];

endmodule

// File: sv/efd_back.sv
// Back end: classifies a finished frame by port code and length and builds
// the report in an output register. Depends on efd_pkg.
module efd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          hb_code_i,
  input  logic [7:0]          prof_code_i,
  input  logic                rec_avail_i,
  input  efd_pkg::frame_rec_t rec_i,
  output logic                rec_take_o,
  input  logic                pop_i,
  output logic                out_valid_o,
  output logic [2:0]          report_kind_o,
  output logic [7:0]          car_number_o,
  output logic [7:0]          car_status_o,
  output logic signed [31:0]  position_now_o,
  output logic signed [31:0]  position_goal_o,
  output logic [31:0]         profile_word_o,
  output logic [7:0]          frame_length_o
);
  import efd_pkg::*;

  logic         valid_q;
  report_kind_e kind_q, kind_d;
  logic [7:0]   car_q, car_d, stat_q, stat_d, len_q;
  logic [31:0]  now_q, now_d, goal_q, goal_d, prof_q, prof_d;
  logic         load;

  // Heartbeat wins when both codes are equal.
  always_comb begin
    kind_d = RPT_UNKNOWN_PORT;
    car_d  = '0;
    stat_d = '0;
    now_d  = '0;
    goal_d = '0;
    prof_d = '0;
    if (rec_i.port == hb_code_i) begin
      if (rec_i.count == HEARTBEAT_LEN) begin
        kind_d = RPT_HEARTBEAT;
        car_d  = rec_i.payload[0];
        stat_d = rec_i.payload[1];
        now_d  = {rec_i.payload[2], rec_i.payload[3], rec_i.payload[4], rec_i.payload[5]};
        goal_d = {rec_i.payload[6], rec_i.payload[7], rec_i.payload[8], rec_i.payload[9]};
      end else begin
        kind_d = RPT_BAD_HEARTBEAT;
      end
    end else if (rec_i.port == prof_code_i) begin
      if (rec_i.count == PROFILE_LEN) begin
        kind_d = RPT_PROFILE;
        prof_d = {rec_i.payload[0], rec_i.payload[1], rec_i.payload[2], rec_i.payload[3]};
      end else begin
        kind_d = RPT_BAD_PROFILE;
      end
    end
  end

  // The output register frees up in the same cycle its request is popped.
  assign load       = rec_avail_i && (!valid_q || pop_i);
  assign rec_take_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (pop_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= kind_d;
      car_q  <= car_d;
      stat_q <= stat_d;
      now_q  <= now_d;
      goal_q <= goal_d;
      prof_q <= prof_d;
      len_q  <= rec_i.count;
    end
  end

  assign out_valid_o     = valid_q;
  assign report_kind_o   = kind_q;
  assign car_number_o    = car_q;
  assign car_status_o    = stat_q;
  assign position_now_o  = now_q;
  assign position_goal_o = goal_q;
  assign profile_word_o  = prof_q;
  assign frame_length_o  = len_q;

endmodule

// File: sv/escaped_frame_decoder_core.sv
// Byte-stuffed frame decoder: one received byte per cycle while not full, one report per frame with a port byte.
// A report passes from its accepted tail byte through the frame queue into the output register.
// Throughput: one byte per cycle; the two-entry frame queue and output register
// absorb output stalls, and push stops only while the frame queue is full.
// Reset: asynchronous, active low; clears control state and the port codes
// to 1 and 2; the first byte after reset is taken as a head byte.
module escaped_frame_decoder_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [7:0]          rx_byte_i,
  output logic                empty,
  input  logic                pop,
  output logic [2:0]          report_kind_o,
  output logic [7:0]          car_number_o,
  output logic [7:0]          car_status_o,
  output logic signed [31:0]  position_now_o,
  output logic signed [31:0]  position_goal_o,
  output logic [31:0]         profile_word_o,
  output logic [7:0]          frame_length_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [efd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]          cfg_data_i
);
  import efd_pkg::*;

  logic [7:0] hb_q, prof_q;
  logic       accept;
  logic       rec_valid, rec_take, fifo_full, fifo_empty, out_valid;
  frame_rec_t rec_wr, rec_rd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hb_q   <= HEARTBEAT_CODE_RST;
      prof_q <= PROFILE_CODE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_HEARTBEAT_IDX: hb_q   <= cfg_data_i;
        CFG_PROFILE_IDX:   prof_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign full   = fifo_full;
  assign accept = push && !full;

  efd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .rx_byte_i   (rx_byte_i),
    .rec_valid_o (rec_valid),
    .rec_o       (rec_wr)
  );

  efd_frame_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (rec_valid),
    .wr_data_i (rec_wr),
    .rd_en_i   (rec_take),
    .rd_data_o (rec_rd),
    .full_o    (fifo_full),
    .empty_o   (fifo_empty)
  );

  efd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .hb_code_i       (hb_q),
    .prof_code_i     (prof_q),
    .rec_avail_i     (!fifo_empty),
    .rec_i           (rec_rd),
    .rec_take_o      (rec_take),
    .pop_i           (pop && out_valid),
    .out_valid_o     (out_valid),
    .report_kind_o   (report_kind_o),
    .car_number_o    (car_number_o),
    .car_status_o    (car_status_o),
    .position_now_o  (position_now_o),
    .position_goal_o (position_goal_o),
    .profile_word_o  (profile_word_o),
    .frame_length_o  (frame_length_o)
  );

  assign empty = !out_valid;

endmodule
